// File: rtl/dans_pkg.sv
// dans_pkg: widths, state and operation codes for the natural display size block
// no dependencies; used by rtl/display_aspect_natural_size.sv
package dans_pkg;

	// field widths
	localparam int DIM_BITS   = 14;
	localparam int RATIO_BITS = 16;
	localparam int SIZE_BITS  = 30;

	// derived datapath widths
	localparam int PROD_BITS = DIM_BITS + RATIO_BITS;
	localparam int WIDE_BITS = DIM_BITS + PROD_BITS;
	localparam int CNT_BITS  = $clog2(WIDE_BITS);
	localparam int K_BITS    = $clog2(PROD_BITS + 1);
	localparam int EXT_BITS  = (WIDE_BITS > SIZE_BITS) ? WIDE_BITS : SIZE_BITS;

	localparam logic [SIZE_BITS-1:0] SIZE_MAX = {SIZE_BITS{1'b1}};

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_GCD,
		ST_GSHL,
		ST_LOAD,
		ST_DIV,
		ST_MUL2,
		ST_OUT
	} dans_state_t;

	// purpose of the current pass through the divider
	typedef enum logic [2:0] {
		OP_DW,
		OP_DH,
		OP_MODH,
		OP_MODW,
		OP_FIN
	} dans_op_t;

	// clamp a wide quotient to the size range
	function automatic logic [SIZE_BITS-1:0] sat_size(input logic [WIDE_BITS-1:0] v);
		logic [EXT_BITS-1:0] ve;
		ve = EXT_BITS'(v);
		if (ve > EXT_BITS'(SIZE_MAX))
			return SIZE_MAX;
		else
			return SIZE_BITS'(ve);
	endfunction

endpackage

// File: rtl/display_aspect_natural_size.sv
// display_aspect_natural_size: natural display size from frame size and pixel aspect ratio
// sequence: done in the cycle after accept for a zero input, else a bit-serial multiply of
// 16 steps, binary gcd, shift-back of the common power of two and five restoring divider
// passes, the fifth after a bit-serial multiply of 14 steps
// handshake: one transaction at a time, busy high until done, next accept once back in idle
// reset: asynchronous, active low, returns to idle with busy and done low
module display_aspect_natural_size (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [dans_pkg::DIM_BITS-1:0]    frame_width,
	input  logic [dans_pkg::DIM_BITS-1:0]    frame_height,
	input  logic [dans_pkg::RATIO_BITS-1:0]  par_numerator,
	input  logic [dans_pkg::RATIO_BITS-1:0]  par_denominator,
	output logic                             done,
	output logic [dans_pkg::SIZE_BITS-1:0]   natural_width,
	output logic [dans_pkg::SIZE_BITS-1:0]   natural_height,
	output logic                             kept_dimension,
	output logic                             bad_input
);

	localparam int DIM   = dans_pkg::DIM_BITS;
	localparam int RATIO = dans_pkg::RATIO_BITS;
	localparam int PROD  = dans_pkg::PROD_BITS;
	localparam int WIDE  = dans_pkg::WIDE_BITS;
	localparam int CNTW  = dans_pkg::CNT_BITS;
	localparam int KW    = dans_pkg::K_BITS;

	dans_pkg::dans_state_t state_q, state_d;
	dans_pkg::dans_op_t    op_q;

	logic [DIM-1:0]   w_q, h_q, m_q;
	logic [RATIO-1:0] n_q, d_q;
	logic [PROD-1:0]  dw_q, dh_q, a_q, b_q;
	logic [KW-1:0]    k_q;
	logic [CNTW-1:0]  cnt_q;
	logic             hmodz_q, kept_q;
	logic [WIDE-1:0]  prod_q;

	logic [WIDE-1:0]  div_num_q;
	logic [PROD-1:0]  div_rem_q, div_den_q;

	logic [dans_pkg::SIZE_BITS-1:0] res_w_q, res_h_q;
	logic                           bad_q;

	logic             accept, any_zero;
	logic             mul_last, mul2_last, div_last;
	logic [PROD-1:0]  acc_w_next, acc_h_next;
	logic             a_eq_b, a_gt_b;
	logic [PROD-1:0]  a_sub_b, b_sub_a;
	logic [PROD:0]    trial, trial_diff;
	logic             fits;
	logic [PROD-1:0]  rem_next;
	logic [WIDE-1:0]  num_next;
	logic [PROD-1:0]  mcand;
	logic [WIDE-1:0]  prod_next;
	logic             keep_width;

	// handshake and step counters
	assign accept    = start && !busy;
	assign any_zero  = (frame_width == '0) || (frame_height == '0) ||
	                   (par_numerator == '0) || (par_denominator == '0);
	assign mul_last  = (cnt_q == CNTW'(RATIO - 1));
	assign mul2_last = (cnt_q == CNTW'(DIM - 1));
	assign div_last  = (cnt_q == CNTW'(WIDE - 1));

	// msb-first shift-add for both display products
	assign acc_w_next = {dw_q[PROD-2:0], 1'b0} + (n_q[RATIO-1] ? PROD'(w_q) : '0);
	assign acc_h_next = {dh_q[PROD-2:0], 1'b0} + (d_q[RATIO-1] ? PROD'(h_q) : '0);

	// binary gcd step terms
	assign a_eq_b  = (a_q == b_q);
	assign a_gt_b  = (a_q > b_q);
	assign a_sub_b = a_q - b_q;
	assign b_sub_a = b_q - a_q;

	// one restoring division step, quotient bits shift in behind the dividend
	assign trial      = {div_rem_q, div_num_q[WIDE-1]};
	assign fits       = (trial >= {1'b0, div_den_q});
	assign trial_diff = trial - {1'b0, div_den_q};
	assign rem_next   = fits ? trial_diff[PROD-1:0] : trial[PROD-1:0];
	assign num_next   = {div_num_q[WIDE-2:0], fits};

	// second product: kept dimension times the opposite reduced term
	assign mcand     = kept_q ? dh_q : dw_q;
	assign prod_next = {prod_q[WIDE-2:0], 1'b0} + (m_q[DIM-1] ? WIDE'(mcand) : '0);

	// width kept only when height is no multiple and width is a multiple
	assign keep_width = !hmodz_q && (rem_next == '0);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= dans_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dans_pkg::ST_IDLE: begin
				if (accept)
					state_d = any_zero ? dans_pkg::ST_OUT : dans_pkg::ST_MUL1;
			end
			dans_pkg::ST_MUL1: begin
				if (mul_last)
					state_d = dans_pkg::ST_GCD;
			end
			dans_pkg::ST_GCD: begin
				if (a_eq_b)
					state_d = dans_pkg::ST_GSHL;
			end
			dans_pkg::ST_GSHL: begin
				if (k_q == '0)
					state_d = dans_pkg::ST_LOAD;
			end
			dans_pkg::ST_LOAD: begin
				state_d = dans_pkg::ST_DIV;
			end
			dans_pkg::ST_DIV: begin
				if (div_last) begin
					case (op_q)
						dans_pkg::OP_MODW: state_d = dans_pkg::ST_MUL2;
						dans_pkg::OP_FIN:  state_d = dans_pkg::ST_OUT;
						default:           state_d = dans_pkg::ST_LOAD;
					endcase
				end
			end
			dans_pkg::ST_MUL2: begin
				if (mul2_last)
					state_d = dans_pkg::ST_LOAD;
			end
			dans_pkg::ST_OUT: begin
				state_d = dans_pkg::ST_IDLE;
			end
			default: state_d = dans_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy = (state_q != dans_pkg::ST_IDLE);
		done = (state_q == dans_pkg::ST_OUT);
	end

	// divider pass selector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= dans_pkg::OP_DW;
		end else begin
			case (state_q)
				dans_pkg::ST_IDLE: op_q <= dans_pkg::OP_DW;
				dans_pkg::ST_DIV: begin
					if (div_last) begin
						case (op_q)
							dans_pkg::OP_DW:   op_q <= dans_pkg::OP_DH;
							dans_pkg::OP_DH:   op_q <= dans_pkg::OP_MODH;
							dans_pkg::OP_MODH: op_q <= dans_pkg::OP_MODW;
							dans_pkg::OP_MODW: op_q <= dans_pkg::OP_FIN;
							default:           op_q <= dans_pkg::OP_DW;
						endcase
					end
				end
				default: op_q <= op_q;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			dans_pkg::ST_IDLE: begin
				if (accept) begin
					w_q     <= frame_width;
					h_q     <= frame_height;
					n_q     <= par_numerator;
					d_q     <= par_denominator;
					dw_q    <= '0;
					dh_q    <= '0;
					cnt_q   <= '0;
					kept_q  <= 1'b0;
					bad_q   <= any_zero;
					res_w_q <= '0;
					res_h_q <= '0;
				end
			end
			dans_pkg::ST_MUL1: begin
				dw_q  <= acc_w_next;
				dh_q  <= acc_h_next;
				n_q   <= {n_q[RATIO-2:0], 1'b0};
				d_q   <= {d_q[RATIO-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
				if (mul_last) begin
					a_q <= acc_w_next;
					b_q <= acc_h_next;
					k_q <= '0;
				end
			end
			dans_pkg::ST_GCD: begin
				if (!a_eq_b) begin
					if (!a_q[0] && !b_q[0]) begin
						a_q <= a_q >> 1;
						b_q <= b_q >> 1;
						k_q <= k_q + 1'b1;
					end else if (!a_q[0]) begin
						a_q <= a_q >> 1;
					end else if (!b_q[0]) begin
						b_q <= b_q >> 1;
					end else if (a_gt_b) begin
						a_q <= a_sub_b >> 1;
					end else begin
						b_q <= b_sub_a >> 1;
					end
				end
			end
			dans_pkg::ST_GSHL: begin
				// restore the common power of two, one bit a cycle
				if (k_q != '0) begin
					a_q <= {a_q[PROD-2:0], 1'b0};
					k_q <= k_q - 1'b1;
				end
			end
			dans_pkg::ST_LOAD: begin
				cnt_q     <= '0;
				div_rem_q <= '0;
				case (op_q)
					dans_pkg::OP_DW: begin
						div_num_q <= WIDE'(dw_q);
						div_den_q <= a_q;
					end
					dans_pkg::OP_DH: begin
						div_num_q <= WIDE'(dh_q);
						div_den_q <= a_q;
					end
					dans_pkg::OP_MODH: begin
						div_num_q <= WIDE'(h_q);
						div_den_q <= dh_q;
					end
					dans_pkg::OP_MODW: begin
						div_num_q <= WIDE'(w_q);
						div_den_q <= dw_q;
					end
					default: begin
						div_num_q <= prod_q;
						div_den_q <= kept_q ? dw_q : dh_q;
					end
				endcase
			end
			dans_pkg::ST_DIV: begin
				div_num_q <= num_next;
				div_rem_q <= rem_next;
				// count restarts at zero on the last step of each pass, for the step that follows
				cnt_q     <= div_last ? '0 : cnt_q + 1'b1;
				if (div_last) begin
					case (op_q)
						dans_pkg::OP_DW:   dw_q    <= PROD'(num_next);
						dans_pkg::OP_DH:   dh_q    <= PROD'(num_next);
						dans_pkg::OP_MODH: hmodz_q <= (rem_next == '0);
						dans_pkg::OP_MODW: begin
							kept_q <= keep_width;
							m_q    <= keep_width ? w_q : h_q;
							prod_q <= '0;
						end
						default: begin
							if (kept_q) begin
								res_w_q <= dans_pkg::SIZE_BITS'(w_q);
								res_h_q <= dans_pkg::sat_size(num_next);
							end else begin
								res_w_q <= dans_pkg::sat_size(num_next);
								res_h_q <= dans_pkg::SIZE_BITS'(h_q);
							end
						end
					endcase
				end
			end
			dans_pkg::ST_MUL2: begin
				prod_q <= prod_next;
				m_q    <= {m_q[DIM-2:0], 1'b0};
				cnt_q  <= cnt_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	// result ports
	assign natural_width  = res_w_q;
	assign natural_height = res_h_q;
	assign kept_dimension = kept_q;
	assign bad_input      = bad_q;

	// result strobe lasts a single cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// a zero input yields zero sizes
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && bad_input) |->
			(natural_width == '0 && natural_height == '0 && !kept_dimension))
		else $error("bad input result carries nonzero fields");

	// the kept dimension passes through unchanged
	a_kept_passes: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !bad_input) |->
			(kept_dimension ? (natural_width == dans_pkg::SIZE_BITS'(w_q))
			                : (natural_height == dans_pkg::SIZE_BITS'(h_q))))
		else $error("kept dimension differs from frame size");

	// gcd operands never reach zero
	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dans_pkg::ST_GCD) |-> (a_q != '0 && b_q != '0))
		else $error("gcd operand reached zero");

	// an accepted transaction makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after accepting a transaction");

endmodule
